// ----- rtl/lpht_pkg.sv -----
// Package for the linear-probing hash table: sizes, operation and status codes.
// Used by the top level and the checker; depends on nothing.
`timescale 1ns / 1ps
package lpht_pkg;
  localparam int Capacity   = 1024;
  localparam int SlotBits   = $clog2(Capacity);
  localparam int CountBits  = SlotBits + 1;
  localparam int KeyBits    = 64;
  localparam int ValueBits  = 64;
  localparam int EntryBits  = 1 + KeyBits + ValueBits + SlotBits;
  localparam logic [10:0] FillLimitReset = 11'd768;

  localparam logic [2:0] OpInsert  = 3'd0;
  localparam logic [2:0] OpFind    = 3'd1;
  localparam logic [2:0] OpRemMark = 3'd2;
  localparam logic [2:0] OpRemComp = 3'd3;
  localparam logic [2:0] OpClear   = 3'd4;
  localparam logic [2:0] OpScan    = 3'd5;

  localparam logic [1:0] StOk     = 2'd0;
  localparam logic [1:0] StAbsent = 2'd1;
  localparam logic [1:0] StFull   = 2'd2;

  typedef struct packed {
    logic                 used;
    logic [KeyBits-1:0]   key;
    logic [ValueBits-1:0] value;
    logic [SlotBits-1:0]  home;
  } entry_t;
endpackage

// ----- rtl/lpht_ram.sv -----
// Generic single-port-write, one-read synchronous RAM with registered read data.
// Depends on nothing.
`timescale 1ns / 1ps
module lpht_ram #(
  parameter int Depth = 1024,
  parameter int Width = 8
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(Depth)-1:0] waddr,
  input  logic [Width-1:0]         wdata,
  input  logic [$clog2(Depth)-1:0] raddr,
  output logic [Width-1:0]         rdata
);
  logic [Width-1:0] mem [Depth];
  always_ff @(posedge clk) begin
    if (we) mem[waddr] <= wdata;
    rdata <= mem[raddr];
  end
endmodule

// ----- rtl/linear_probe_hash_table.sv -----
// Top level of the linear-probing hash table: sequencer and slot RAM.
// Depends on lpht_pkg and lpht_ram.
`timescale 1ns / 1ps
// One item is taken when start is high and busy is low; its single result
// appears on the result ports for one cycle with done high and cannot be
// held off. Each slot, including its occupied bit, lives in one RAM with
// registered read data. A probe step addresses a slot in S_READ and examines
// its data in S_CHECK, and the result strobe comes in the cycle where busy
// falls. A scan likewise reads and examines each slot in turn (S_SREAD, then
// S_SCAN). Backward-shift compaction then reads and examines each slot behind
// the removed one (S_CREAD, then S_CCHECK) and frees the last hole in S_FREE.
// An insert refused as full and an unknown code go straight to the reply.
// Clear all walks the whole table with a clearing pass over all 1024 slots,
// then replies. After reset the same clearing pass runs with busy high and
// gives no result.
module linear_probe_hash_table (
  input  logic        clk,
  input  logic        rst,
  input  logic        start,
  output logic        busy,
  input  logic [2:0]  operation,
  input  logic [63:0] key,
  input  logic [9:0]  home_slot,
  input  logic [63:0] value,
  input  logic [9:0]  scan_from,
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic [10:0] cfg_data,
  output logic        done,
  output logic [1:0]  status,
  output logic        overwrote,
  output logic [63:0] found_key,
  output logic [63:0] found_value,
  output logic [9:0]  slot_index,
  output logic [10:0] entry_count
);
  localparam int SB = lpht_pkg::SlotBits;
  localparam int CB = lpht_pkg::CountBits;

  typedef enum logic [3:0] {
    S_IDLE, S_READ, S_CHECK, S_SREAD, S_SCAN, S_CREAD, S_CCHECK, S_FREE, S_WIPE, S_REPLY
  } state_t;

  state_t state;
  logic [10:0] fill_limit;
  logic [CB-1:0] used_count;
  logic [2:0] op;
  logic [lpht_pkg::KeyBits-1:0] req_key;
  logic [lpht_pkg::ValueBits-1:0] req_value;
  logic [SB-1:0] req_home, pos, hole;
  logic [CB-1:0] probes;

  logic we;
  logic [SB-1:0] waddr, raddr;
  lpht_pkg::entry_t wdata, rdata;

  assign cfg_ready = !busy;
  assign busy = (state != S_IDLE);
  assign entry_count = used_count;

  lpht_ram #(.Depth(lpht_pkg::Capacity), .Width(lpht_pkg::EntryBits)) u_ram (
    .clk(clk), .we(we), .waddr(waddr), .wdata(wdata), .raddr(raddr), .rdata(rdata)
  );

  logic [SB-1:0] pos_inc;
  assign pos_inc = pos + 1'b1;
  assign raddr = pos;
  // Cyclic distances: from the entry's home and from the hole to its slot.
  logic [SB-1:0] d_home, d_hole;
  assign d_home = pos - rdata.home;
  assign d_hole = pos - hole;

  // During compaction the slot an entry leaves becomes the new hole; it is
  // only marked free once, when the shifting stops.
  always_comb begin
    we = 1'b0;
    waddr = pos;
    wdata = '{used: 1'b1, key: req_key, value: req_value, home: req_home};
    if (state == S_WIPE) begin
      we = 1'b1;
      wdata = '0;
    end else if (state == S_CHECK && op == lpht_pkg::OpInsert) begin
      we = !rdata.used || rdata.key == req_key;
      if (rdata.used) wdata.home = rdata.home;
    end else if (state == S_CHECK
                 && (op == lpht_pkg::OpRemMark || op == lpht_pkg::OpRemComp)) begin
      we = rdata.used && rdata.key == req_key;
      wdata = rdata;
      wdata.used = 1'b0;
    end else if (state == S_CCHECK) begin
      we = rdata.used && d_home >= d_hole;
      waddr = hole;
      wdata = rdata;
    end else if (state == S_FREE) begin
      we = 1'b1;
      waddr = hole;
      wdata = '0;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      // The clearing pass after reset ends without a reply.
      state <= S_WIPE;
      pos <= '0;
      op <= lpht_pkg::OpFind;
      fill_limit <= lpht_pkg::FillLimitReset;
      used_count <= '0;
      done <= 1'b0;
    end else begin
      done <= (state == S_REPLY);
      if (cfg_valid && cfg_ready) fill_limit <= cfg_data;
      unique case (state)
        S_IDLE: if (start) begin
          op <= operation;
          req_key <= key;
          req_value <= value;
          req_home <= home_slot;
          probes <= '0;
          overwrote <= 1'b0;
          found_key <= '0;
          found_value <= '0;
          slot_index <= '0;
          unique case (operation)
            lpht_pkg::OpInsert: begin
              pos <= home_slot;
              if (CB'(used_count + 1'b1) > fill_limit) begin
                status <= lpht_pkg::StFull;
                state <= S_REPLY;
              end else begin
                status <= lpht_pkg::StAbsent;
                state <= S_READ;
              end
            end
            lpht_pkg::OpFind, lpht_pkg::OpRemMark, lpht_pkg::OpRemComp: begin
              pos <= home_slot;
              status <= lpht_pkg::StAbsent;
              state <= S_READ;
            end
            lpht_pkg::OpClear: begin
              used_count <= '0;
              status <= lpht_pkg::StOk;
              pos <= '0;
              state <= S_WIPE;
            end
            lpht_pkg::OpScan: begin
              pos <= scan_from;
              status <= lpht_pkg::StAbsent;
              state <= S_SREAD;
            end
            default: begin
              status <= lpht_pkg::StAbsent;
              state <= S_REPLY;
            end
          endcase
        end
        S_READ: state <= S_CHECK;
        S_CHECK: begin
          if (!rdata.used) begin
            if (op == lpht_pkg::OpInsert) begin
              used_count <= used_count + 1'b1;
              status <= lpht_pkg::StOk;
              slot_index <= pos;
            end
            state <= S_REPLY;
          end else if (rdata.key == req_key) begin
            status <= lpht_pkg::StOk;
            slot_index <= pos;
            if (op == lpht_pkg::OpInsert) begin
              overwrote <= 1'b1;
              state <= S_REPLY;
            end else if (op == lpht_pkg::OpFind) begin
              found_value <= rdata.value;
              state <= S_REPLY;
            end else begin
              used_count <= used_count - 1'b1;
              if (op == lpht_pkg::OpRemComp) begin
                hole <= pos;
                pos <= pos_inc;
                probes <= CB'(1);
                state <= S_CREAD;
              end else begin
                state <= S_REPLY;
              end
            end
          end else if (probes == CB'(lpht_pkg::Capacity - 1)) begin
            if (op == lpht_pkg::OpInsert) status <= lpht_pkg::StFull;
            state <= S_REPLY;
          end else begin
            pos <= pos_inc;
            probes <= probes + 1'b1;
            state <= S_READ;
          end
        end
        S_SREAD: state <= S_SCAN;
        S_SCAN: begin
          if (rdata.used) begin
            status <= lpht_pkg::StOk;
            found_key <= rdata.key;
            found_value <= rdata.value;
            slot_index <= pos;
            state <= S_REPLY;
          end else if (pos == SB'(lpht_pkg::Capacity - 1)) begin
            state <= S_REPLY;
          end else begin
            pos <= pos_inc;
            state <= S_SREAD;
          end
        end
        S_CREAD: state <= S_CCHECK;
        S_CCHECK: begin
          if (!rdata.used) begin
            state <= S_FREE;
          end else begin
            if (d_home >= d_hole) hole <= pos;
            if (probes == CB'(lpht_pkg::Capacity - 1)) begin
              state <= S_FREE;
            end else begin
              pos <= pos_inc;
              probes <= probes + 1'b1;
              state <= S_CREAD;
            end
          end
        end
        S_FREE: state <= S_REPLY;
        S_WIPE: begin
          if (pos == SB'(lpht_pkg::Capacity - 1)) begin
            state <= (op == lpht_pkg::OpClear) ? S_REPLY : S_IDLE;
          end else begin
            pos <= pos_inc;
          end
        end
        S_REPLY: state <= S_IDLE;
        default: state <= S_IDLE;
      endcase
    end
  end
endmodule

// ----- rtl/lpht_checker.sv -----
// Port-level checker for the hash table, bound to the top level.
// Depends on lpht_pkg and linear_probe_hash_table.
`timescale 1ns / 1ps
module lpht_checker (
  input logic        clk,
  input logic        rst,
  input logic        start,
  input logic        busy,
  input logic        done,
  input logic [1:0]  status,
  input logic        overwrote,
  input logic [10:0] entry_count
);
  a_start_busy: assert property (@(posedge clk) disable iff (rst)
    start && !busy |=> busy) else $error("accepted item did not raise busy");
  a_done_ends: assert property (@(posedge clk) disable iff (rst)
    done |-> !busy) else $error("result while still busy");
  a_over_ok: assert property (@(posedge clk) disable iff (rst)
    done && overwrote |-> status == lpht_pkg::StOk) else $error("overwrite without success");
  a_count: assert property (@(posedge clk) disable iff (rst)
    !busy && !done |=> $stable(entry_count) || busy) else $error("count moved idle");
endmodule

bind linear_probe_hash_table lpht_checker u_chk (
  .clk(clk), .rst(rst), .start(start), .busy(busy), .done(done),
  .status(status), .overwrote(overwrote), .entry_count(entry_count)
);
